// ===== rtl/kda_pkg.sv =====
// Shared types, constants and register codes for the key debounce and auto-repeat block.
// Used by the key update logic, the top level and the checker; depends on nothing.
package kda_pkg;

  localparam int NUM_KEY_SLOTS = 8;
  localparam int FILTER_BITS   = 2;

  // Fixed field widths of the request and event items.
  localparam int KEY_W  = 3;
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 8;

  // Slot index width, never wider than the key field that addresses it.
  localparam int SLOT_LOG = (NUM_KEY_SLOTS > 1) ? $clog2(NUM_KEY_SLOTS) : 1;
  localparam int SLOT_W   = (SLOT_LOG < KEY_W) ? SLOT_LOG : KEY_W;

  // Stream and register port widths.
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 8;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // Register index codes, taken from paddr[3:2].
  localparam logic [1:0] REG_LONG_DELAY   = 2'd0;
  localparam logic [1:0] REG_REPEAT_START = 2'd1;
  localparam logic [1:0] REG_RATE_STEP    = 2'd2;
  localparam logic [1:0] REG_PAUSE_LENGTH = 2'd3;

  localparam logic [CFG_W-1:0] LONG_DELAY_RST   = 8'd32;
  localparam logic [CFG_W-1:0] REPEAT_START_RST = 8'd40;
  localparam logic [CFG_W-1:0] RATE_STEP_RST    = 8'd48;
  localparam logic [CFG_W-1:0] PAUSE_LENGTH_RST = 8'd64;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_PAUSE = 2'd1,
    OP_KILL  = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    EV_FIRST  = 2'd0,
    EV_REPEAT = 2'd1,
    EV_LONG   = 2'd2,
    EV_BREAK  = 2'd3
  } ev_e;

  typedef enum logic [3:0] {
    MODE_OFF    = 4'd0,
    MODE_START  = 4'd1,
    MODE_DELAY  = 4'd2,
    MODE_PAUSED = 4'd3,
    MODE_KILLED = 4'd4,
    MODE_REP16  = 4'd5,
    MODE_REP8   = 4'd6,
    MODE_REP4   = 4'd7,
    MODE_REP2   = 4'd8,
    MODE_REP1   = 4'd9
  } mode_e;

  typedef struct packed {
    logic [CFG_W-1:0] long_delay;
    logic [CFG_W-1:0] repeat_start;
    logic [CFG_W-1:0] rate_step_length;
    logic [CFG_W-1:0] pause_length;
  } cfg_t;

  typedef struct packed {
    logic [FILTER_BITS-1:0] hist;
    mode_e                  mode;
    logic [CNT_W-1:0]       cnt;
  } key_state_t;

  typedef struct packed {
    logic valid;
    ev_e  kind;
  } event_t;

  function automatic logic slot_ok(logic [KEY_W-1:0] key);
    return int'(key) < NUM_KEY_SLOTS;
  endfunction

endpackage

// ===== rtl/kda_key_update.sv =====
// Next-state and event logic for one key: applies a tick, pause or kill request.
// Depends on kda_pkg for the state, configuration and event types.
module kda_key_update (
  input  kda_pkg::op_e        op_i,
  input  logic                level_i,
  input  kda_pkg::key_state_t cur_i,
  input  kda_pkg::cfg_t       cfg_i,
  output kda_pkg::key_state_t nxt_o,
  output kda_pkg::event_t     ev_o
);
  import kda_pkg::*;

  logic [FILTER_BITS-1:0] hist_n;
  logic [CNT_W-1:0]       cnt_inc;
  logic [CNT_W-1:0]       rep_mask;
  mode_e                  rep_mode;

  always_comb begin
    hist_n  = FILTER_BITS'({cur_i.hist, level_i});
    cnt_inc = cur_i.cnt + 8'd1;

    // Interval step: leaving an interval clears the count, so an event follows at once.
    rep_mode = cur_i.mode;
    if (cur_i.mode != MODE_REP1 && cnt_inc >= cfg_i.rate_step_length) begin
      rep_mode = mode_e'(cur_i.mode + 4'd1);
    end
    case (rep_mode)
      MODE_REP16: rep_mask = 8'd15;
      MODE_REP8:  rep_mask = 8'd7;
      MODE_REP4:  rep_mask = 8'd3;
      MODE_REP2:  rep_mask = 8'd1;
      default:    rep_mask = 8'd0;
    endcase
  end

  always_comb begin
    nxt_o      = cur_i;
    ev_o.valid = 1'b0;
    ev_o.kind  = EV_FIRST;
    case (op_i)
      OP_TICK: begin
        nxt_o.hist = hist_n;
        nxt_o.cnt  = cnt_inc;
        if (cur_i.mode != MODE_OFF && hist_n == '0) begin
          ev_o.valid = (cur_i.mode != MODE_KILLED);
          ev_o.kind  = EV_BREAK;
          nxt_o.mode = MODE_OFF;
          nxt_o.cnt  = '0;
        end else begin
          case (cur_i.mode)
            MODE_START: begin
              ev_o.valid = 1'b1;
              ev_o.kind  = EV_FIRST;
              nxt_o.mode = MODE_DELAY;
              nxt_o.cnt  = '0;
            end
            MODE_DELAY: begin
              if (cnt_inc == cfg_i.long_delay) begin
                ev_o.valid = 1'b1;
                ev_o.kind  = EV_LONG;
              end
              if (cnt_inc == cfg_i.repeat_start) begin
                nxt_o.mode = MODE_REP16;
                nxt_o.cnt  = '0;
              end
            end
            MODE_REP16, MODE_REP8, MODE_REP4, MODE_REP2, MODE_REP1: begin
              nxt_o.mode = rep_mode;
              if (rep_mode != cur_i.mode) begin
                nxt_o.cnt = '0;
              end
              ev_o.valid = ((nxt_o.cnt & rep_mask) == '0);
              ev_o.kind  = EV_REPEAT;
            end
            MODE_PAUSED: begin
              if (cnt_inc >= cfg_i.pause_length) begin
                nxt_o.mode = MODE_REP8;
                nxt_o.cnt  = '0;
              end
            end
            MODE_KILLED: begin
              nxt_o.mode = MODE_KILLED;
            end
            default: begin
              // Idle, or a code that cannot occur, which behaves as idle.
              nxt_o.mode = MODE_OFF;
              if (hist_n == '1) begin
                nxt_o.mode = MODE_START;
                nxt_o.cnt  = '0;
              end
            end
          endcase
        end
      end
      OP_PAUSE: begin
        nxt_o.mode = MODE_PAUSED;
        nxt_o.cnt  = '0;
      end
      OP_KILL: begin
        nxt_o.mode = MODE_KILLED;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ===== rtl/key_debounce_autorepeat.sv =====
// Top level of the key debounce and auto-repeat block: stream ports, register port,
// per-key state and the output register. Depends on kda_pkg and kda_key_update.

// A request enters an input register, is resolved against its key's state and leaves
// through an output register. One request is accepted every cycle while the output is
// not stalled, with a single read-modify-write of the per-key state per request; a
// stalled output holds the pipeline for as long as m_axis_tready stays low. Per-key
// state sits in flip-flops and is cleared by reset, so no start-up sweep is needed.
// Registers are to be written over APB only while no request is in flight; the block
// itself does not enforce it.
module key_debounce_autorepeat (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2:0] key_index, [3] level, [7:4] zero
  input  logic [kda_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  // [1:0] op
  input  logic [kda_pkg::OP_W-1:0]             s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] event_key, [7:3] zero
  output logic [kda_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // [1:0] event_kind
  output logic [kda_pkg::KIND_W-1:0]           m_axis_tuser,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kda_pkg::APB_AW-1:0]           paddr,
  input  logic [kda_pkg::APB_DW-1:0]           pwdata,
  output logic [kda_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready
);
  import kda_pkg::*;

  cfg_t cfg_q;

  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [KEY_W-1:0] s1_key_q;
  logic             s1_level_q;
  logic             s1_adv;
  logic             s1_hit;

  logic [FILTER_BITS-1:0] hist_q [NUM_KEY_SLOTS];
  mode_e                  mode_q [NUM_KEY_SLOTS];
  logic [CNT_W-1:0]       cnt_q  [NUM_KEY_SLOTS];
  logic [SLOT_W-1:0]      slot;

  key_state_t cur_state;
  key_state_t nxt_state;
  event_t     ev;

  logic             out_valid_q;
  ev_e              out_kind_q;
  logic [KEY_W-1:0] out_key_q;

  // Register port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_delay       <= LONG_DELAY_RST;
      cfg_q.repeat_start     <= REPEAT_START_RST;
      cfg_q.rate_step_length <= RATE_STEP_RST;
      cfg_q.pause_length     <= PAUSE_LENGTH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LONG_DELAY:   cfg_q.long_delay       <= pwdata[CFG_W-1:0];
        REG_REPEAT_START: cfg_q.repeat_start     <= pwdata[CFG_W-1:0];
        REG_RATE_STEP:    cfg_q.rate_step_length <= pwdata[CFG_W-1:0];
        REG_PAUSE_LENGTH: cfg_q.pause_length     <= pwdata[CFG_W-1:0];
        default:          cfg_q                  <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LONG_DELAY:   prdata = APB_DW'(cfg_q.long_delay);
      REG_REPEAT_START: prdata = APB_DW'(cfg_q.repeat_start);
      REG_RATE_STEP:    prdata = APB_DW'(cfg_q.rate_step_length);
      REG_PAUSE_LENGTH: prdata = APB_DW'(cfg_q.pause_length);
      default:          prdata = '0;
    endcase
  end

  // The input register moves on whenever the output register is free or being emptied.
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op_q    <= op_e'(s_axis_tuser);
      s1_key_q   <= s_axis_tdata[KEY_W-1:0];
      s1_level_q <= s_axis_tdata[KEY_W];
    end
  end

  // Per-key state, read and written back at the key held in the input register.
  assign slot   = s1_key_q[SLOT_W-1:0];
  assign s1_hit = s1_valid_q && s1_adv && slot_ok(s1_key_q);

  assign cur_state.hist = hist_q[slot];
  assign cur_state.mode = mode_q[slot];
  assign cur_state.cnt  = cnt_q[slot];

  kda_key_update u_update (
    .op_i    (s1_op_q),
    .level_i (s1_level_q),
    .cur_i   (cur_state),
    .cfg_i   (cfg_q),
    .nxt_o   (nxt_state),
    .ev_o    (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
        hist_q[i] <= '0;
        mode_q[i] <= MODE_OFF;
        cnt_q[i]  <= '0;
      end
    end else if (s1_hit) begin
      hist_q[slot] <= nxt_state.hist;
      mode_q[slot] <= nxt_state.mode;
      cnt_q[slot]  <= nxt_state.cnt;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_hit && ev.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_hit && ev.valid) begin
      out_kind_q <= ev.kind;
      out_key_q  <= s1_key_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = M_TDATA_W'(out_key_q);

endmodule

// ===== rtl/kda_checker.sv =====
// Port-level checks for key_debounce_autorepeat, attached to it by the bind below.
// Depends on kda_pkg for port widths.
module kda_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kda_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [kda_pkg::KIND_W-1:0]    m_axis_tuser,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [kda_pkg::APB_AW-1:0]    paddr,
  input logic [kda_pkg::APB_DW-1:0]    pwdata,
  input logic [kda_pkg::APB_DW-1:0]    prdata,
  input logic                          pready
);
  import kda_pkg::*;

  logic in_acc;
  logic cfg_wr0;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_wr0 = psel && penable && pwrite && pready && (paddr[3:2] == REG_LONG_DELAY);

  // A fresh event needs a request taken before it, across the input and output registers.
  a_event_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_acc, 2))
    else $error("event appeared without a matching request");

  // A write to the long_delay register reads back its new value on the next cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr0 ##1 (paddr[3:2] == REG_LONG_DELAY) |-> (prdata == APB_DW'($past(pwdata[CFG_W-1:0]))))
    else $error("long_delay register did not read back its written value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("event dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled event changed");

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker (.*);

// ===== bench/tb_key_debounce_autorepeat.sv =====
`timescale 1ns / 100ps
// Self-checking bench for key_debounce_autorepeat: stream requests in, key events out.
// A per-key debounce and repeat model predicts every event; needs kda_pkg and the RTL.
module tb_key_debounce_autorepeat;
  import kda_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic             level;
  } key_req_t;

  typedef struct packed {
    ev_e              kind;
    logic [KEY_W-1:0] key;
  } key_event_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // Shadow copy of the block's registers and per-key state.
  cfg_t                   cfg;
  logic [FILTER_BITS-1:0] key_hist [NUM_KEY_SLOTS];
  mode_e                  key_mode [NUM_KEY_SLOTS];
  logic [CNT_W-1:0]       key_cnt  [NUM_KEY_SLOTS];

  key_req_t   req_q[$];
  key_event_t pending_events[$];
  key_req_t   cur_req;
  key_event_t want;

  bit failed = 1'b0;
  bit req_taken = 1'b0;
  bit hold_off = 1'b0;
  int accepted_total = 0;
  int src_gap = 0;
  int src_calm = 0;
  int sink_stall = 0;
  int sink_calm = 0;
  int cycle_count = 0;

  key_debounce_autorepeat u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_event(ev_e kind, logic [KEY_W-1:0] k);
    key_event_t e;
    e.kind = kind;
    e.key  = k;
    pending_events.push_back(e);
  endfunction

  function automatic void track_key(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic lvl);
    logic [FILTER_BITS-1:0] h;
    mode_e                  m;
    logic [CNT_W-1:0]       c;
    int unsigned            span;
    if (int'(k) >= NUM_KEY_SLOTS) return;
    case (op)
      OP_PAUSE: begin
        key_mode[k] = MODE_PAUSED;
        key_cnt[k]  = '0;
      end
      OP_KILL: key_mode[k] = MODE_KILLED;
      OP_TICK: begin
        h = FILTER_BITS'({key_hist[k], lvl});
        m = key_mode[k];
        c = key_cnt[k] + 1'b1;
        key_hist[k] = h;
        if (m != MODE_OFF && h == '0) begin
          // Release: a killed key goes quiet without a break event.
          if (m != MODE_KILLED) note_event(EV_BREAK, k);
          key_mode[k] = MODE_OFF;
          key_cnt[k]  = '0;
        end else begin
          case (m)
            MODE_START: begin
              note_event(EV_FIRST, k);
              m = MODE_DELAY;
              c = '0;
            end
            MODE_DELAY: begin
              if (c == cfg.long_delay) note_event(EV_LONG, k);
              if (c == cfg.repeat_start) begin
                m = MODE_REP16;
                c = '0;
              end
            end
            MODE_PAUSED: begin
              if (c >= cfg.pause_length) begin
                m = MODE_REP8;
                c = '0;
              end
            end
            MODE_KILLED: ;
            MODE_REP16, MODE_REP8, MODE_REP4, MODE_REP2, MODE_REP1: begin
              if (m != MODE_REP1 && c >= cfg.rate_step_length) begin
                m = mode_e'(m + 1);
                c = '0;
              end
              span = 16 >> (m - MODE_REP16);
              if ((c & (span - 1)) == 0) note_event(EV_REPEAT, k);
            end
            default: begin
              m = MODE_OFF;
              if (&h) begin
                m = MODE_START;
                c = '0;
              end
            end
          endcase
          key_mode[k] = m;
          key_cnt[k]  = c;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic lvl);
    key_req_t r;
    r.op    = op;
    r.key   = k;
    r.level = lvl;
    req_q.push_back(r);
  endfunction

  function automatic void queue_noise();
    queue_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic void queue_hold(logic [KEY_W-1:0] k, int len);
    for (int i = 0; i < len; i++) queue_req(OP_TICK, k, 1'b1);
  endfunction

  // Press and release sequences with random content, sprinkled with commands,
  // glitches and unrelated requests.
  task automatic build_press_traffic(input int n_items, input int max_hold);
    int               base;
    int               r;
    int               hold;
    logic [KEY_W-1:0] k;
    base = req_q.size();
    while (req_q.size() - base < n_items) begin
      k = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) begin
        queue_noise();
      end else begin
        hold = $urandom_range(2, max_hold);
        for (int i = 0; i < hold; i++) begin
          r = $urandom_range(0, 99);
          if (r < 6) queue_noise();
          else if (r < 8) queue_req(OP_PAUSE, k, 1'($urandom_range(0, 1)));
          else if (r < 9) queue_req(OP_KILL, k, 1'($urandom_range(0, 1)));
          else if (r < 12) queue_req(OP_TICK, k, 1'b0);
          queue_req(OP_TICK, k, 1'b1);
        end
        hold = $urandom_range(1, 3);
        for (int i = 0; i < hold; i++) queue_req(OP_TICK, k, 1'b0);
      end
    end
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_LONG_DELAY:   cfg.long_delay = value;
      REG_REPEAT_START: cfg.repeat_start = value;
      REG_RATE_STEP:    cfg.rate_step_length = value;
      default:          cfg.pause_length = value;
    endcase
  endtask

  task automatic program_all(input logic [CFG_W-1:0] ld, input logic [CFG_W-1:0] rs,
                             input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] pl);
    program_reg(REG_LONG_DELAY, ld);
    program_reg(REG_REPEAT_START, rs);
    program_reg(REG_RATE_STEP, st);
    program_reg(REG_PAUSE_LENGTH, pl);
  endtask

  // Waits until every request is taken and every event is in, then lets the
  // pipeline empty out so that requests without an event have settled too.
  task automatic settle_block();
    while (req_q.size() != 0 || s_axis_tvalid || pending_events.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Request driver.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        cur_req = req_q.pop_front();
        s_axis_tuser  <= cur_req.op;
        s_axis_tdata  <= {4'b0000, cur_req.level, cur_req.key};
        s_axis_tvalid <= 1'b1;
        src_gap = pick_gap(src_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Event receiver backpressure.
  always @(negedge clk_i) begin
    if (hold_off || sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      if (sink_stall > 0) sink_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      sink_stall = pick_gap(sink_calm);
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted event.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_key(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[3]);
        req_taken = 1'b1;
        accepted_total++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event: kind %0d key %0d", m_axis_tuser, m_axis_tdata[2:0]);
          failed = 1'b1;
        end else begin
          want = pending_events.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("event_kind mismatch: expected %0d, got %0d", want.kind, m_axis_tuser);
            failed = 1'b1;
          end
          if (m_axis_tdata[2:0] !== want.key) begin
            $error("event_key mismatch: expected %0d, got %0d", want.key, m_axis_tdata[2:0]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps pushing requests.
  initial begin
    while (accepted_total < 400) @(negedge clk_i);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("key_debounce_autorepeat test failed");
    $finish;
  end

  initial begin
    cfg.long_delay       = LONG_DELAY_RST;
    cfg.repeat_start     = REPEAT_START_RST;
    cfg.rate_step_length = RATE_STEP_RST;
    cfg.pause_length     = PAUSE_LENGTH_RST;
    for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
      key_hist[i] = '0;
      key_mode[i] = MODE_OFF;
      key_cnt[i]  = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: long and repeat start on the same tick, the fastest halving,
    // a pause that expires at once, a kill and its silent release, an unused op.
    program_all(8'd3, 8'd3, 8'd1, 8'd0);
    queue_hold(3'd0, 11);
    queue_req(OP_PAUSE, 3'd0, 1'b1);
    queue_hold(3'd0, 2);
    queue_req(OP_KILL, 3'd0, 1'b0);
    queue_req(OP_TICK, 3'd0, 1'b0);
    queue_req(OP_TICK, 3'd0, 1'b0);
    queue_req(2'd3, 3'd7, 1'b1);
    queue_hold(3'd7, 3);
    queue_req(OP_TICK, 3'd7, 1'b0);
    queue_req(OP_TICK, 3'd7, 1'b0);
    settle_block();

    program_all(LONG_DELAY_RST, REPEAT_START_RST, RATE_STEP_RST, PAUSE_LENGTH_RST);
    build_press_traffic(150, 120);
    settle_block();

    // Lowest settings; one hold runs long enough for the counter to wrap.
    program_all(8'd0, 8'd0, 8'd0, 8'd0);
    queue_hold(3'd5, 270);
    queue_req(OP_TICK, 3'd5, 1'b0);
    queue_req(OP_TICK, 3'd5, 1'b0);
    build_press_traffic(100, 40);
    settle_block();

    program_all(8'($urandom_range(1, 20)), 8'($urandom_range(1, 30)),
                8'($urandom_range(1, 10)), 8'($urandom_range(1, 20)));
    build_press_traffic(150, 40);
    settle_block();

    program_all(8'd255, 8'd255, 8'd255, 8'd255);
    build_press_traffic(80, 30);
    settle_block();

    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("key_debounce_autorepeat test passed");
    else
      $display("key_debounce_autorepeat test failed");
    $finish;
  end

endmodule

// ===== key_debounce_autorepeat.f =====
rtl/kda_pkg.sv
rtl/kda_key_update.sv
rtl/key_debounce_autorepeat.sv
rtl/kda_checker.sv
bench/tb_key_debounce_autorepeat.sv
